/* hdl/slptf_pkg.sv */
package slptf_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF    = 4096;
   localparam int unsigned PAGE_OFFSET_BITS_DEF = 12;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned SIZE_W  = 32;
   localparam int unsigned REQ_W   = 13;
   localparam int unsigned TOT_W   = 32;
   localparam int unsigned BYTES_W = 44;

   typedef struct packed {
      logic [ADDR_W-1:0] logical_address;
      logic [SIZE_W-1:0] request_size;
   } req_type;

   typedef struct packed {
      logic [REQ_W-1:0]   request_hits;
      logic [REQ_W-1:0]   request_faults;
      logic [TOT_W-1:0]   total_hits;
      logic [TOT_W-1:0]   total_faults;
      logic [BYTES_W-1:0] bytes_allocated;
      logic               table_overrun;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear_en;
      logic load_en;
      logic walk_en;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic walk_done;
   } dp_status_type;

endpackage

/* hdl/slptf_ram.sv */
module slptf_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 2,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/slptf_ctrl.sv */
module slptf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  slptf_pkg::dp_status_type status,
   output slptf_pkg::ctl_cmd_type   cmd,
   output logic                     busy,
   output logic                     rsp_strobe
);
   import slptf_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_WALK;
                  busy_ff  <= 1'b1;
               end
            end
            ST_WALK: begin
               if (status.walk_done) begin
                  state_ff  <= ST_IDLE;
                  busy_ff   <= 1'b0;
                  strobe_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
               busy_ff  <= 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      cmd.clear_en = (state_ff == ST_CLEAR);
      cmd.load_en  = (state_ff == ST_IDLE) && start;
      cmd.walk_en  = (state_ff == ST_WALK);
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

/* hdl/slptf_dp.sv */
module slptf_dp #(
   parameter int unsigned TABLE_ENTRIES    = slptf_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned PAGE_OFFSET_BITS = slptf_pkg::PAGE_OFFSET_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  slptf_pkg::ctl_cmd_type   cmd,
   input  slptf_pkg::req_type       req_data,
   output slptf_pkg::dp_status_type status,
   output slptf_pkg::rsp_type       rsp_data
);
   import slptf_pkg::*;

   localparam int unsigned PN_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned WIDE_W = SIZE_W + 1;

   // request decode
   logic [WIDE_W-1:0] start_pn;
   logic [WIDE_W-1:0] pages;
   logic [WIDE_W-1:0] room;
   logic              oor_calc;
   logic [WIDE_W-1:0] walk_calc;

   // walk state
   logic [PN_W-1:0]    page_ff, page_in;
   logic [CNT_W-1:0]   remain_ff, remain_in;
   logic               pend_ff, pend_in;
   logic [PN_W-1:0]    pend_page_ff, pend_page_in;
   logic [PN_W-1:0]    clr_addr_ff, clr_addr_in;
   logic               oor_ff, oor_in;
   logic [REQ_W-1:0]   req_hits_ff, req_hits_in;
   logic [REQ_W-1:0]   req_faults_ff, req_faults_in;
   logic [TOT_W-1:0]   tot_hits_ff, tot_hits_in;
   logic [TOT_W-1:0]   tot_faults_ff, tot_faults_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [BYTES_W:0]   bytes_sum;

   // table port
   logic            issue;
   logic            ram_we;
   logic [PN_W-1:0] ram_waddr;
   logic            ram_wdata;
   logic            ram_rdata;

   always_comb begin
      start_pn  = {1'b0, req_data.logical_address} >> PAGE_OFFSET_BITS;
      pages     = ({1'b0, req_data.request_size} >> PAGE_OFFSET_BITS)
                + WIDE_W'(|(req_data.request_size & SIZE_W'((64'd1 << PAGE_OFFSET_BITS) - 64'd1)));
      room      = (start_pn < WIDE_W'(TABLE_ENTRIES)) ? WIDE_W'(TABLE_ENTRIES) - start_pn : '0;
      oor_calc  = pages > room;
      walk_calc = oor_calc ? room : pages;
   end

   assign issue     = cmd.walk_en && (remain_ff != '0);
   assign bytes_sum = {1'b0, bytes_ff} + ((BYTES_W + 1)'(1) << PAGE_OFFSET_BITS);

   always_comb begin
      page_in       = page_ff;
      remain_in     = remain_ff;
      pend_in       = 1'b0;
      pend_page_in  = page_ff;
      clr_addr_in   = clr_addr_ff;
      oor_in        = oor_ff;
      req_hits_in   = req_hits_ff;
      req_faults_in = req_faults_ff;
      tot_hits_in   = tot_hits_ff;
      tot_faults_in = tot_faults_ff;
      bytes_in      = bytes_ff;
      ram_we        = 1'b0;
      ram_waddr     = pend_page_ff;
      ram_wdata     = 1'b1;

      if (cmd.clear_en) begin
         ram_we      = 1'b1;
         ram_waddr   = clr_addr_ff;
         ram_wdata   = 1'b0;
         clr_addr_in = clr_addr_ff + PN_W'(1);
      end

      if (cmd.load_en) begin
         page_in       = start_pn[PN_W-1:0];
         remain_in     = walk_calc[CNT_W-1:0];
         oor_in        = oor_calc;
         req_hits_in   = '0;
         req_faults_in = '0;
      end

      if (issue) begin
         page_in   = page_ff + PN_W'(1);
         remain_in = remain_ff - CNT_W'(1);
         pend_in   = 1'b1;
      end

      // registered read data of the page issued last cycle
      if (cmd.walk_en && pend_ff) begin
         if (ram_rdata) begin
            if (req_hits_ff != '1) req_hits_in = req_hits_ff + REQ_W'(1);
            if (tot_hits_ff != '1) tot_hits_in = tot_hits_ff + TOT_W'(1);
         end else begin
            ram_we = 1'b1;
            if (req_faults_ff != '1) req_faults_in = req_faults_ff + REQ_W'(1);
            if (tot_faults_ff != '1) tot_faults_in = tot_faults_ff + TOT_W'(1);
            bytes_in = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         remain_ff     <= '0;
         clr_addr_ff   <= '0;
         tot_hits_ff   <= '0;
         tot_faults_ff <= '0;
         bytes_ff      <= '0;
      end else begin
         pend_ff       <= pend_in;
         remain_ff     <= remain_in;
         clr_addr_ff   <= clr_addr_in;
         tot_hits_ff   <= tot_hits_in;
         tot_faults_ff <= tot_faults_in;
         bytes_ff      <= bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      pend_page_ff  <= pend_page_in;
      oor_ff        <= oor_in;
      req_hits_ff   <= req_hits_in;
      req_faults_ff <= req_faults_in;
   end

   slptf_ram #(
      .WIDTH (1),
      .DEPTH (TABLE_ENTRIES)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (issue),
      .rd_addr (page_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      status.clear_last = (clr_addr_ff == PN_W'(TABLE_ENTRIES - 1));
      status.walk_done  = (remain_ff == '0) && !pend_ff;

      rsp_data.request_hits    = req_hits_ff;
      rsp_data.request_faults  = req_faults_ff;
      rsp_data.total_hits      = tot_hits_ff;
      rsp_data.total_faults    = tot_faults_ff;
      rsp_data.bytes_allocated = bytes_ff;
      rsp_data.table_overrun   = oor_ff;
   end

endmodule

/* hdl/single_level_page_table_fill.sv */
// single-level page table fill: each item (byte address, byte length) walks the
// pages it covers, starting at address >> PAGE_OFFSET_BITS, one table entry per
// cycle. a mapped page counts a hit; an unmapped one counts a fault, gets mapped
// and adds one page size to the allocated byte total. a walk that reaches page
// TABLE_ENTRIES stops there and flags table_overrun; pages already walked keep
// their updates. after reset the block clears the mapped bits of all
// TABLE_ENTRIES entries in one pass, holding busy high. an accepted item makes
// one memory read per page through the single read port of the mapped-bit
// table; the registered read data of each page is checked and the page mapped
// if needed, then the walk is seen finished and the result is strobed. an item
// that walks no page goes straight from the finished check to its result.
// busy drops in the cycle the result strobe is high, so a new item can be
// started then. the result is shown for exactly one cycle with rsp_strobe high
// and cannot be held off by the receiver; capture it then.
// totals saturate at their maximum values and report unchanged for a zero size.
module single_level_page_table_fill #(
   parameter int unsigned TABLE_ENTRIES    = slptf_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned PAGE_OFFSET_BITS = slptf_pkg::PAGE_OFFSET_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  slptf_pkg::req_type req_data,
   output logic               rsp_strobe,
   output slptf_pkg::rsp_type rsp_data
);
   import slptf_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // sequencer: clear pass, idle, walk
   slptf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // page counters, mapped-bit table and running totals
   slptf_dp #(
      .TABLE_ENTRIES    (TABLE_ENTRIES),
      .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // a result strobe never lasts more than one cycle
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   // an accepted item keeps the block busy until its result
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("busy not raised after an accepted item");

   // one item never touches more pages than the table holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ({1'b0, rsp_data.request_hits} + {1'b0, rsp_data.request_faults}
                      <= (REQ_W + 1)'(TABLE_ENTRIES)) || (TABLE_ENTRIES > 8191))
      else $error("page count of an item exceeds the table");

   // the totals only move while an item is being walked
   assert property (@(posedge clock) disable iff (reset)
      (!busy && !$past(busy) && !$past(reset)) |->
         ($stable(rsp_data.total_hits) && $stable(rsp_data.total_faults)
          && $stable(rsp_data.bytes_allocated)))
      else $error("totals changed while idle");

endmodule

/* dv/single_level_page_table_fill_tb.sv */
module single_level_page_table_fill_tb;
   import slptf_pkg::*;

   // table geometry, taken from the package defaults the block is built with
   localparam longint unsigned ENTRIES    = TABLE_ENTRIES_DEF;
   localparam int unsigned     PAGE_BITS  = PAGE_OFFSET_BITS_DEF;
   localparam longint unsigned PAGE_BYTES = 64'd1 << PAGE_BITS;
   localparam longint unsigned REQ_MAX    = (64'd1 << REQ_W) - 1;
   localparam longint unsigned CNT_MAX    = (64'd1 << TOT_W) - 1;
   localparam longint unsigned BYTES_MAX  = (64'd1 << BYTES_W) - 1;

   // quiet cycles allowed: clearing pass plus one full-table walk, with margin to spare
   localparam int unsigned QUIET_LIMIT = 20000;
   localparam int unsigned RANDOM_ITEMS = 1350;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // predictor state: mapped flag per page and the running totals
   bit              mapped_model [ENTRIES];
   longint unsigned hit_total;
   longint unsigned fault_total;
   longint unsigned bytes_total;

   rsp_type     fill_expected [$];
   int unsigned mismatch_count;
   int unsigned quiet_cycles;
   bit          steady_sender;

   single_level_page_table_fill u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // walk the pages one item covers and return what the block should report
   function automatic rsp_type predict_fill(req_type rq);
      longint unsigned first_page;
      longint unsigned page_count;
      longint unsigned room;
      longint unsigned walk;
      longint unsigned pn;
      longint unsigned hits;
      longint unsigned faults;
      bit              beyond;
      rsp_type         r;
      first_page = 64'(rq.logical_address >> PAGE_BITS);
      page_count = 64'(rq.request_size >> PAGE_BITS)
                 + (((rq.request_size & (PAGE_BYTES - 1)) != 0) ? 64'd1 : 64'd0);
      room       = (first_page < ENTRIES) ? ENTRIES - first_page : 64'd0;
      // the walk stops at the first page past the table
      beyond     = page_count > room;
      walk       = beyond ? room : page_count;
      hits       = 0;
      faults     = 0;
      for (pn = first_page; pn < first_page + walk; pn++) begin
         if (mapped_model[pn]) begin
            hits++;
            if (hit_total < CNT_MAX) hit_total++;
         end else begin
            faults++;
            mapped_model[pn] = 1'b1;
            if (fault_total < CNT_MAX) fault_total++;
            bytes_total = (bytes_total > BYTES_MAX - PAGE_BYTES) ? BYTES_MAX
                                                                 : bytes_total + PAGE_BYTES;
         end
      end
      r.request_hits    = REQ_W'((hits > REQ_MAX) ? REQ_MAX : hits);
      r.request_faults  = REQ_W'((faults > REQ_MAX) ? REQ_MAX : faults);
      r.total_hits      = TOT_W'(hit_total);
      r.total_faults    = TOT_W'(fault_total);
      r.bytes_allocated = BYTES_W'(bytes_total);
      r.table_overrun   = beyond;
      return r;
   endfunction

   // present one item at a falling edge and hold it until the block takes it
   task automatic send_request(req_type rq);
      int unsigned gap;
      gap = (!steady_sender && $urandom_range(0, 99) < 15) ? $urandom_range(1, 6) : 0;
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy !== 1'b0);
      // taken at this edge: predict now so the order matches the results
      fill_expected.push_back(predict_fill(rq));
   endtask

   task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // results cannot be held off, so every strobe is taken at its rising edge
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (fill_expected.size() == 0) begin
            $error("result with no item outstanding: 0x%0h", rsp_data);
            mismatch_count++;
         end else begin
            exp_rsp = fill_expected.pop_front();
            compare_field("request_hits", 64'(exp_rsp.request_hits),
                          64'(rsp_data.request_hits));
            compare_field("request_faults", 64'(exp_rsp.request_faults),
                          64'(rsp_data.request_faults));
            compare_field("total_hits", 64'(exp_rsp.total_hits), 64'(rsp_data.total_hits));
            compare_field("total_faults", 64'(exp_rsp.total_faults),
                          64'(rsp_data.total_faults));
            compare_field("bytes_allocated", 64'(exp_rsp.bytes_allocated),
                          64'(rsp_data.bytes_allocated));
            compare_field("table_overrun", 64'(exp_rsp.table_overrun),
                          64'(rsp_data.table_overrun));
         end
      end
   end

   // watchdog: counts edges at which neither an item nor a result moves
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // zero length walks nothing, wherever it starts
   task automatic test_zero_size();
      send_request(req_type'{32'h0000_0000, 32'h0000_0000});
      send_request(req_type'{32'hFFFF_FFFF, 32'h0000_0000});
      send_request(req_type'{32'h00AB_C123, 32'h0000_0000});
   endtask

   // first fault, then hits on the same page, then a length spilling one byte over
   task automatic test_single_page();
      send_request(req_type'{32'h0000_0000, 32'h0000_0001});
      send_request(req_type'{32'h0000_0FFF, 32'h0000_1000});
      send_request(req_type'{32'h0000_0800, 32'h0000_1001});
      send_request(req_type'{32'h0000_3000, 32'h0000_2FFF});
   endtask

   // last page, a walk running off the end, and starts past the table
   task automatic test_table_end();
      send_request(req_type'{32'h00FF_F000, 32'h0000_0001});
      send_request(req_type'{32'h00FF_FFFF, 32'h0000_2000});
      send_request(req_type'{32'h0100_0000, 32'h0000_0001});
      send_request(req_type'{32'hFFFF_FFFF, 32'hFFFF_FFFF});
      send_request(req_type'{32'h0100_0000, 32'h0000_0000});
      send_request(req_type'{32'h00FF_E000, 32'h8000_0000});
   endtask

   // mostly short walks inside the table, some revisiting the last region for hits,
   // plus long lengths near the top and starts anywhere in the address space
   task automatic test_random_fill();
      req_type     rq;
      logic [31:0] last_addr;
      int unsigned kind;
      last_addr = 32'h0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady_sender = (i >= 500 && i < 750);
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            rq.logical_address = $urandom_range(0, (1 << 24) - 1);
            rq.request_size    = $urandom_range(0, 6 * PAGE_BYTES);
         end else if (kind < 68) begin
            rq.logical_address = last_addr + $urandom_range(0, 2 * PAGE_BYTES);
            rq.request_size    = $urandom_range(1, 4 * PAGE_BYTES);
         end else if (kind < 83) begin
            // huge length, but the start is close enough to the top to keep walks short
            rq.logical_address = {8'h00, 12'($urandom_range(ENTRIES - 64, ENTRIES - 1)),
                                  12'($urandom)};
            rq.request_size    = $urandom;
         end else if (kind < 95) begin
            rq.logical_address = $urandom | 32'h0100_0000;
            rq.request_size    = $urandom;
         end else begin
            rq.logical_address = $urandom;
            rq.request_size    = 32'h0;
         end
         last_addr = rq.logical_address;
         send_request(rq);
      end
      steady_sender = 1'b0;
   endtask

   // whole-table walks and a short one: the first maps every page left, the others only hit
   task automatic test_full_table();
      send_request(req_type'{32'h0000_0000, 32'hFFFF_FFFF});
      send_request(req_type'{32'h0000_0FFF, 32'h0100_0000});
      send_request(req_type'{32'h0000_1000, 32'h00FF_F001});
      send_request(req_type'{32'h0042_1000, 32'h0000_5000});
   endtask

   initial begin
      mismatch_count = 0;
      quiet_cycles   = 0;
      steady_sender  = 1'b0;
      hit_total      = 0;
      fault_total    = 0;
      bytes_total    = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the clearing pass after reset shows up as busy, so no wait here
      test_zero_size();
      test_single_page();
      test_table_end();
      test_random_fill();
      test_full_table();

      @(negedge clock);
      start <= 1'b0;
      while (fill_expected.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* files.f */
hdl/slptf_pkg.sv
hdl/slptf_ram.sv
hdl/slptf_ctrl.sv
hdl/slptf_dp.sv
hdl/single_level_page_table_fill.sv
dv/single_level_page_table_fill_tb.sv
